// ===== rtl/aes_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// AES-128 package
// Shared payload types, item kinds, sequencer states and the round functions.
// -----------------------------------------------------------------------------
package aes_pkg;

  localparam int KeyCount = 11;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_ENC  = 2'd1,
    KIND_DEC  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_FETCH = 2'd1,
    ST_ROUND = 2'd2,
    ST_DONE  = 2'd3
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  key_slot;
    logic [63:0] data_high;
    logic [63:0] data_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic        was_decrypt;
  } out_item_t;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic load;
    logic first;
    logic last;
    logic step;
    logic dec;
  } rnd_ctl_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gmul = p;
  endfunction

  // Inverse in GF(2^8) as x^254 by square and multiply.
  function automatic logic [7:0] ginv(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] b;
    r = 8'h01;
    b = x;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gmul(r, b);
      b = gmul(b, b);
    end
    ginv = r;
  endfunction

  function automatic logic [7:0] rotl(input logic [7:0] v, input int n);
    rotl = (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] b;
    b = ginv(x);
    sbox_calc = b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] isbox_calc(input logic [7:0] y);
    isbox_calc = ginv(rotl(y, 1) ^ rotl(y, 3) ^ rotl(y, 6) ^ 8'h05);
  endfunction

  // Constant S-box tables, evaluated at elaboration.
  function automatic logic [255:0][7:0] mk_sbox(input logic inv);
    logic [255:0][7:0] t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inv ? isbox_calc(8'(i)) : sbox_calc(8'(i));
    end
    mk_sbox = t;
  endfunction

  localparam logic [255:0][7:0] SBOX  = mk_sbox(1'b0);
  localparam logic [255:0][7:0] ISBOX = mk_sbox(1'b1);

endpackage
`default_nettype wire

// ===== rtl/aes_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// AES round unit
// One shared round datapath for encryption and decryption, one round a cycle.
// -----------------------------------------------------------------------------
module aes_round (
  input  wire logic              clk,
  input  wire aes_pkg::rnd_ctl_t ctl,
  input  wire logic [127:0]      blk_in,
  input  wire logic [127:0]      rkey,
  output logic [127:0]           state
);
  import aes_pkg::*;

  logic [127:0] state_r;
  logic [127:0] state_nxt;
  logic [7:0]   s  [16];
  logic [7:0]   k  [16];
  logic [7:0]   sh [16];
  logic [7:0]   sb [16];
  logic [7:0]   ak [16];
  logic [7:0]   mx [16];

  // Byte view: byte i in row i mod 4, column i div 4.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_r[127 - 8 * i -: 8];
      k[i] = rkey[127 - 8 * i -: 8];
    end
    // Encrypt: SubBytes, ShiftRows, MixColumns, AddRoundKey.
    // Decrypt: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns.
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (ctl.dec) begin
          sh[r + 4 * ((c + r) & 3)] = s[r + 4 * c];
        end else begin
          sh[r + 4 * c] = s[r + 4 * ((c + r) & 3)];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      sb[i] = ctl.dec ? ISBOX[sh[i]] : SBOX[sh[i]];
    end
    for (int i = 0; i < 16; i++) begin
      ak[i] = ctl.dec ? (sb[i] ^ k[i]) : sb[i];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (ctl.dec) begin
          mx[4 * c + r] = gmul(8'h0e, ak[4 * c + r])
                        ^ gmul(8'h0b, ak[4 * c + ((r + 1) & 3)])
                        ^ gmul(8'h0d, ak[4 * c + ((r + 2) & 3)])
                        ^ gmul(8'h09, ak[4 * c + ((r + 3) & 3)]);
        end else begin
          mx[4 * c + r] = xtime(ak[4 * c + r])
                        ^ xtime(ak[4 * c + ((r + 1) & 3)]) ^ ak[4 * c + ((r + 1) & 3)]
                        ^ ak[4 * c + ((r + 2) & 3)] ^ ak[4 * c + ((r + 3) & 3)];
        end
      end
    end
    state_nxt = state_r;
    if (ctl.first) begin
      state_nxt = state_r ^ rkey;
    end else if (ctl.step) begin
      for (int i = 0; i < 16; i++) begin
        if (ctl.dec) begin
          state_nxt[127 - 8 * i -: 8] = ctl.last ? ak[i] : mx[i];
        end else begin
          state_nxt[127 - 8 * i -: 8] = (ctl.last ? ak[i] : mx[i]) ^ k[i];
        end
      end
    end
    if (ctl.load) begin
      state_nxt = blk_in;
    end
  end

  // Working block register.
  always_ff @(posedge clk) begin
    state_r <= state_nxt;
  end

  assign state = state_r;

endmodule
`default_nettype wire

// ===== rtl/aes128_block_cipher_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// AES-128 block cipher
// Iterative cipher over a loaded key schedule, one round per cycle.
// -----------------------------------------------------------------------------
// Channel  Direction  Payload
// in_      input      kind, key_slot, data_high, data_low
// out_     output     result_high, result_low, was_decrypt
//
// A load transfer writes one key slot, if in range, and the input stays ready.
// A cipher item passes a key fetch from the key memory, the initial key
// addition, ten rounds on the shared round unit, then the result register.
// The input stalls while a block is in flight or its result waits.
// Reset clears the sequencer only; key slots hold nothing until loaded.
module aes128_block_cipher_top #(
  parameter int ROUND_KEY_COUNT = 11
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire aes_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output aes_pkg::out_item_t     out_data
);
  import aes_pkg::*;

  localparam int LastKey = ROUND_KEY_COUNT - 1;

  state_t       state_r;
  state_t       state_nxt;
  logic [3:0]   rnd_r;
  logic [3:0]   rnd_nxt;
  logic         dec_r;
  logic [127:0] key_mem [ROUND_KEY_COUNT];
  logic [127:0] rkey_r;
  logic [3:0]   raddr;
  rnd_ctl_t     ctl;
  logic [127:0] blk;
  logic         acc;

  assign acc = in_valid && !in_stall;

  // Key memory: written by load transfers, read one slot a cycle.
  always_ff @(posedge clk) begin
    if (acc && kind_t'(in_data.kind) == KIND_LOAD
        && in_data.key_slot < 4'(ROUND_KEY_COUNT)) begin
      key_mem[in_data.key_slot] <= {in_data.data_high, in_data.data_low};
    end
    rkey_r <= key_mem[raddr];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && (kind_t'(in_data.kind) == KIND_ENC
                    || kind_t'(in_data.kind) == KIND_DEC)) begin
          state_nxt = ST_FETCH;
          rnd_nxt   = 4'd0;
        end
      end
      ST_FETCH: state_nxt = ST_ROUND;
      ST_ROUND: begin
        rnd_nxt = rnd_r + 4'd1;
        if (rnd_r == 4'(LastKey)) state_nxt = ST_DONE;
      end
      ST_DONE: if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    out_valid = (state_r == ST_DONE);
    ctl.load  = (state_r == ST_IDLE) && acc;
    ctl.first = (state_r == ST_ROUND) && rnd_r == 4'd0;
    ctl.step  = (state_r == ST_ROUND) && rnd_r != 4'd0;
    ctl.last  = rnd_r == 4'(LastKey);
    ctl.dec   = dec_r;
    // Key slot for the next round step.
    if (state_r == ST_ROUND) begin
      raddr = dec_r ? 4'(LastKey - 1) - rnd_r : rnd_r + 4'd1;
    end else begin
      raddr = dec_r ? 4'(LastKey) : 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= 4'd0;
      dec_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      if (ctl.load) dec_r <= (kind_t'(in_data.kind) == KIND_DEC);
    end
  end

  aes_round u_round (
    .clk    (clk),
    .ctl    (ctl),
    .blk_in ({in_data.data_high, in_data.data_low}),
    .rkey   (rkey_r),
    .state  (blk)
  );

  assign out_data.result_high = blk[127:64];
  assign out_data.result_low  = blk[63:0];
  assign out_data.was_decrypt = dec_r;

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// AES-128 block cipher testbench
// Loads key schedules, sends encrypt and decrypt blocks with random idling on
// both channels, and checks each result against an in-bench cipher model.
// -----------------------------------------------------------------------------
module tb_top;
  import aes_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  aes128_block_cipher_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Key schedule as the model sees it, plus work queues.
  logic [127:0] key_sched [KeyCount];
  in_item_t     pending_items[$];
  out_item_t    expected_blocks[$];
  int           mismatch_count;
  int           idle_pct;
  bit           hold_sender;
  int           result_count;

  function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
    end
    return p;
  endfunction

  function automatic logic [7:0] gf_inverse(input logic [7:0] x);
    logic [7:0] r;
    r = 8'h01;
    // x^254 is x^2 * x^4 * ... * x^128.
    for (int i = 1; i < 8; i++) begin
      x = gf_mult(x, x);
      r = gf_mult(r, x);
    end
    return r;
  endfunction

  function automatic logic [7:0] rot8(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [7:0] sub_byte(input logic [7:0] x, input bit inverse);
    logic [7:0] b;
    if (inverse) begin
      return gf_inverse(rot8(x, 1) ^ rot8(x, 3) ^ rot8(x, 6) ^ 8'h05);
    end
    b = gf_inverse(x);
    return b ^ rot8(b, 1) ^ rot8(b, 2) ^ rot8(b, 3) ^ rot8(b, 4) ^ 8'h63;
  endfunction

  // Byte i of the block sits in bits 127-8i downto 120-8i; row i%4, column i/4.
  function automatic logic [127:0] aes_cipher(input logic [127:0] blk, input bit decrypt);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] cf [4];
    logic [127:0] k;
    int kidx;
    for (int i = 0; i < 16; i++) s[i] = blk[127 - 8*i -: 8];
    if (decrypt) cf = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else cf = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int rnd = 0; rnd < KeyCount; rnd++) begin
      kidx = decrypt ? KeyCount - 1 - rnd : rnd;
      // Forward order: SubBytes, ShiftRows, MixColumns but in the last round, then the key.
      if (rnd != 0 && !decrypt) begin
        for (int i = 0; i < 16; i++) s[i] = sub_byte(s[i], 1'b0);
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) t[r + 4*c] = s[r + 4*((c + r) & 3)];
        s = t;
        if (rnd != KeyCount - 1) begin
          for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
              t[4*c + r] = 8'h00;
              for (int j = 0; j < 4; j++)
                t[4*c + r] ^= gf_mult(cf[(j - r + 4) & 3], s[4*c + j]);
            end
          s = t;
        end
      end
      // Inverse order: InvShiftRows, InvSubBytes, then the key.
      if (rnd != 0 && decrypt) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) t[r + 4*((c + r) & 3)] = s[r + 4*c];
        s = t;
        for (int i = 0; i < 16; i++) s[i] = sub_byte(s[i], 1'b1);
      end
      k = key_sched[kidx];
      for (int i = 0; i < 16; i++) s[i] ^= k[127 - 8*i -: 8];
      // InvMixColumns follows every key but the first and last.
      if (decrypt && rnd != 0 && rnd != KeyCount - 1) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) begin
            t[4*c + r] = 8'h00;
            for (int j = 0; j < 4; j++)
              t[4*c + r] ^= gf_mult(cf[(j - r + 4) & 3], s[4*c + j]);
          end
        s = t;
      end
    end
    for (int i = 0; i < 16; i++) blk[127 - 8*i -: 8] = s[i];
    return blk;
  endfunction

  // Update the key schedule or queue the expected block for one transfer.
  task automatic predict_transfer(input in_item_t it);
    out_item_t ex;
    logic [127:0] r;
    case (kind_t'(it.kind))
      KIND_LOAD: begin
        if (it.key_slot < KeyCount) key_sched[it.key_slot] = {it.data_high, it.data_low};
      end
      KIND_ENC, KIND_DEC: begin
        r = aes_cipher({it.data_high, it.data_low}, it.kind == KIND_DEC);
        ex.result_high = r[127:64];
        ex.result_low  = r[63:0];
        ex.was_decrypt = (it.kind == KIND_DEC);
        expected_blocks.push_back(ex);
      end
      default: begin
      end
    endcase
  endtask

  function automatic in_item_t make_item(input kind_t k, input logic [3:0] slot,
                                         input logic [63:0] hi, input logic [63:0] lo);
    in_item_t it;
    it.kind = k;
    it.key_slot = slot;
    it.data_high = hi;
    it.data_low = lo;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Driver: one transfer per accepted edge, idling at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_transfer(in_data);
      if (!hold_sender && pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result with the oldest expected block.
  always @(posedge clk) begin
    out_item_t ex;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_blocks.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %h", out_data);
        end else begin
          ex = expected_blocks.pop_front();
          if (out_data.result_high !== ex.result_high || out_data.result_low !== ex.result_low
              || out_data.was_decrypt !== ex.was_decrypt) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected %h %h %b, actual %h %h %b",
                       ex.result_high, ex.result_low, ex.was_decrypt,
                       out_data.result_high, out_data.result_low, out_data.was_decrypt);
          end
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic load_schedule();
    for (int s = 0; s < KeyCount; s++)
      pending_items.push_back(make_item(KIND_LOAD, 4'(s), rand64(), rand64()));
  endtask

  // Drain the pipeline: sender quiet until every expected result is in.
  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_blocks.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    kind_t k;
    int n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    mismatch_count = 0;
    result_count = 0;
    idle_pct = 36;
    hold_sender = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: FIPS-197 appendix C.1 key in slot 0 and vector, random other slots, then extremes.
    pending_items.push_back(make_item(KIND_LOAD, 4'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f));
    for (int s = 1; s < KeyCount; s++)
      pending_items.push_back(make_item(KIND_LOAD, 4'(s), rand64(), rand64()));
    pending_items.push_back(make_item(KIND_ENC, 4'hf, 64'h0011223344556677, 64'h8899aabbccddeeff));
    pending_items.push_back(make_item(KIND_DEC, 4'h0, 64'h0, 64'h0));
    pending_items.push_back(make_item(KIND_ENC, 4'h0, '1, '1));
    pending_items.push_back(make_item(KIND_DEC, 4'hf, '1, '1));
    // Out-of-range slots and the unused kind leave the key slots and results alone.
    pending_items.push_back(make_item(KIND_LOAD, 4'd11, '1, '1));
    pending_items.push_back(make_item(KIND_LOAD, 4'd15, rand64(), rand64()));
    pending_items.push_back(make_item(KIND_NONE, 4'd5, '1, '1));
    pending_items.push_back(make_item(KIND_ENC, 4'd10, 64'h0, '1));
    pending_items.push_back(make_item(KIND_LOAD, 4'd10, '1, 64'h0));
    pending_items.push_back(make_item(KIND_DEC, 4'd3, '1, 64'h0));
    wait_drained();

    // Random: mostly cipher blocks, occasional key reloads and noise.
    n = 0;
    while (n < 1750) begin
      if (n == 600) begin
        wait_drained();
        idle_pct = 0;
      end
      if (n == 900) begin
        wait_drained();
        idle_pct = 36;
      end
      if ($urandom_range(99) < 3) begin
        load_schedule();
        n += KeyCount;
      end else begin
        case ($urandom_range(19))
          0: k = KIND_LOAD;
          1: k = KIND_NONE;
          default: k = $urandom_range(1) ? KIND_ENC : KIND_DEC;
        endcase
        pending_items.push_back(make_item(k, 4'($urandom), rand64(), rand64()));
        if (k != KIND_NONE) n++;
      end
      if (pending_items.size() > 40) begin
        while (pending_items.size() > 10) @(posedge clk);
      end
    end
    wait_drained();

    if (mismatch_count == 0 && expected_blocks.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit: far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/aes_pkg.sv
rtl/aes_round.sv
rtl/aes128_block_cipher_top.sv
dv/tb_top.sv
